>>> sv/bounded_circular_list_engine_macros.svh
// assertion helpers for the list engine checker
`ifndef BOUNDED_CIRCULAR_LIST_ENGINE_MACROS_SVH
`define BOUNDED_CIRCULAR_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define BCL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list engine check failed");

// next-cycle implication
`define BCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

>>> sv/bcl_pkg.sv
`timescale 1ns / 1ps
package bcl_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int CFG_W      = 5;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 80;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_DROP_POLICY = 1'b1;

  typedef enum logic [3:0] {
    OP_ADD_FIRST  = 4'd0,
    OP_ADD_LAST   = 4'd1,
    OP_ADD_AFTER  = 4'd2,
    OP_ADD_BEFORE = 4'd3,
    OP_DELETE     = 4'd4,
    OP_FIRST      = 4'd5,
    OP_LAST       = 4'd6,
    OP_NEXT       = 4'd7,
    OP_PREV       = 4'd8,
    OP_DATA       = 4'd9,
    OP_WALK       = 4'd10,
    OP_CLEAR      = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_REF = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LINK_RD,
    S_QUERY_RD,
    S_UNLINK,
    S_INSERT,
    S_INS_RD,
    S_INS_FIX,
    S_WALK_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    status_t status;
    slot_t   handle;
    word_t   data;
    cnt_t    size;
    logic    evicted_valid;
    word_t   evicted_data;
    logic    last;
  } result_t;

  typedef struct packed {
    slot_t rd_addr;
    logic  nx_we;
    slot_t nx_addr;
    slot_t nx_wdata;
    logic  pv_we;
    slot_t pv_addr;
    slot_t pv_wdata;
    logic  dt_we;
    slot_t dt_addr;
    word_t dt_wdata;
  } mem_req_t;

  typedef struct packed {
    slot_t nx;
    slot_t pv;
    word_t dt;
  } mem_rsp_t;

  // lowest free slot
  function automatic slot_t first_free(input logic [POOL_DEPTH-1:0] v);
    slot_t s;
    s = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (!v[i]) s = SLOT_W'(i);
    end
    return s;
  endfunction

endpackage

>>> sv/bcl_node_ram.sv
`timescale 1ns / 1ps
module bcl_node_ram (
  input  logic              clk,
  input  bcl_pkg::mem_req_t req,
  output bcl_pkg::mem_rsp_t rsp
);

  bcl_pkg::slot_t nx_mem [bcl_pkg::POOL_DEPTH];
  bcl_pkg::slot_t pv_mem [bcl_pkg::POOL_DEPTH];
  bcl_pkg::word_t dt_mem [bcl_pkg::POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (req.nx_we) nx_mem[req.nx_addr] <= req.nx_wdata;
    if (req.pv_we) pv_mem[req.pv_addr] <= req.pv_wdata;
    if (req.dt_we) dt_mem[req.dt_addr] <= req.dt_wdata;
    rsp.nx <= nx_mem[req.rd_addr];
    rsp.pv <= pv_mem[req.rd_addr];
    rsp.dt <= dt_mem[req.rd_addr];
  end

endmodule

>>> sv/bcl_out_reg.sv
`timescale 1ns / 1ps
module bcl_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          emit,
  input  bcl_pkg::result_t              res,
  output logic                          take,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bcl_pkg::OUT_W-1:0]     m_tdata,
  output logic                          m_tlast
);

  bcl_pkg::result_t hold;

  assign take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) hold <= res;
  end

  assign m_tdata = {4'b0, hold.evicted_data, hold.evicted_valid, hold.size,
                    hold.data, hold.handle, hold.status};
  assign m_tlast = hold.last;

endmodule

>>> sv/bcl_ctrl.sv
`timescale 1ns / 1ps
module bcl_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bcl_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bcl_pkg::IN_W-1:0]    in_data,
  output logic                        emit,
  output bcl_pkg::result_t            res,
  input  logic                        take,
  output bcl_pkg::mem_req_t           mreq,
  input  bcl_pkg::mem_rsp_t           mrsp
);

  bcl_pkg::state_t state, state_next;
  bcl_pkg::op_t    op;
  bcl_pkg::slot_t  ref_h, cur, cur_next, rr, rr_next, nb, nb_next;
  bcl_pkg::slot_t  head, head_next, tail, tail_next;
  bcl_pkg::cnt_t   count, count_next, walk_i, walk_i_next, limit;
  bcl_pkg::word_t  din, evd, evd_next;
  logic            ev, ev_next, rwh, rwh_next, ins_before, ins_before_next;
  logic [bcl_pkg::POOL_DEPTH-1:0] valid, valid_next;
  logic [bcl_pkg::CFG_W-1:0] max_entries;
  logic            drop_policy;
  bcl_pkg::result_t res_next;
  logic            hok, is_add;

  assign in_ready = (state == bcl_pkg::S_IDLE);
  assign emit     = (state == bcl_pkg::S_EMIT);
  assign limit = (max_entries == '0 || max_entries > bcl_pkg::CFG_W'(bcl_pkg::POOL_DEPTH))
                 ? bcl_pkg::CNT_W'(bcl_pkg::POOL_DEPTH) : bcl_pkg::CNT_W'(max_entries);
  assign hok    = valid[ref_h];
  assign is_add = (op == bcl_pkg::OP_ADD_FIRST) || (op == bcl_pkg::OP_ADD_LAST) ||
                  (op == bcl_pkg::OP_ADD_AFTER) || (op == bcl_pkg::OP_ADD_BEFORE);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= '0;
      drop_policy <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcl_pkg::CFG_MAX_ENTRIES: max_entries <= cfg_wdata;
        bcl_pkg::CFG_DROP_POLICY: drop_policy <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcl_pkg::S_IDLE;
      valid <= '0;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op    <= bcl_pkg::op_t'(in_data[3:0]);
      ref_h <= in_data[7:4];
      din   <= in_data[39:8];
    end
    cur        <= cur_next;
    rr         <= rr_next;
    nb         <= nb_next;
    walk_i     <= walk_i_next;
    ev         <= ev_next;
    evd        <= evd_next;
    rwh        <= rwh_next;
    ins_before <= ins_before_next;
    res        <= res_next;
  end

  always_comb begin
    state_next      = state;
    valid_next      = valid;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    cur_next        = cur;
    rr_next         = rr;
    nb_next         = nb;
    walk_i_next     = walk_i;
    ev_next         = ev;
    evd_next        = evd;
    rwh_next        = rwh;
    ins_before_next = ins_before;
    res_next        = res;
    mreq            = '0;

    unique case (state)
      bcl_pkg::S_IDLE: begin
        ev_next  = 1'b0;
        evd_next = '0;
        rwh_next = 1'b0;
        if (in_valid) state_next = bcl_pkg::S_DECODE;
      end

      bcl_pkg::S_DECODE: begin
        res_next = '{status: bcl_pkg::ST_OK, handle: '0, data: '0, size: count,
                     evicted_valid: 1'b0, evicted_data: '0, last: 1'b1};
        state_next = bcl_pkg::S_EMIT;
        if (is_add) begin
          if ((op == bcl_pkg::OP_ADD_AFTER || op == bcl_pkg::OP_ADD_BEFORE) && !hok) begin
            res_next.status = bcl_pkg::ST_BAD_REF;
          end else if (count >= limit) begin
            if (!drop_policy) begin
              res_next.status = bcl_pkg::ST_FULL;
            end else begin
              ev_next  = 1'b1;
              rwh_next = (op == bcl_pkg::OP_ADD_AFTER || op == bcl_pkg::OP_ADD_BEFORE)
                         && ref_h == head;
              cur_next = head;
              mreq.rd_addr = head;
              state_next = bcl_pkg::S_UNLINK;
            end
          end else begin
            state_next = bcl_pkg::S_INSERT;
          end
        end else begin
          unique case (op)
            bcl_pkg::OP_DELETE: begin
              if (!hok) res_next.status = bcl_pkg::ST_BAD_REF;
              else begin
                cur_next = ref_h;
                mreq.rd_addr = ref_h;
                state_next = bcl_pkg::S_UNLINK;
              end
            end
            bcl_pkg::OP_FIRST, bcl_pkg::OP_LAST: begin
              if (count == '0) res_next.status = bcl_pkg::ST_EMPTY;
              else begin
                cur_next = (op == bcl_pkg::OP_FIRST) ? head : tail;
                mreq.rd_addr = cur_next;
                state_next = bcl_pkg::S_QUERY_RD;
              end
            end
            bcl_pkg::OP_NEXT, bcl_pkg::OP_PREV, bcl_pkg::OP_DATA: begin
              if (!hok) res_next.status = bcl_pkg::ST_BAD_REF;
              else begin
                cur_next = ref_h;
                mreq.rd_addr = ref_h;
                state_next = (op == bcl_pkg::OP_DATA) ? bcl_pkg::S_QUERY_RD
                                                      : bcl_pkg::S_LINK_RD;
              end
            end
            bcl_pkg::OP_WALK, bcl_pkg::OP_CLEAR: begin
              if (count == '0) res_next.status = bcl_pkg::ST_EMPTY;
              else begin
                cur_next    = head;
                walk_i_next = '0;
                mreq.rd_addr = head;
                state_next = bcl_pkg::S_WALK_RD;
              end
            end
            default: ;  // unused codes report the size
          endcase
        end
      end

      bcl_pkg::S_LINK_RD: begin
        cur_next = (op == bcl_pkg::OP_NEXT) ? mrsp.nx : mrsp.pv;
        mreq.rd_addr = cur_next;
        state_next = bcl_pkg::S_QUERY_RD;
      end

      bcl_pkg::S_QUERY_RD: begin
        res_next = '{status: bcl_pkg::ST_OK, handle: cur, data: mrsp.dt, size: count,
                     evicted_valid: 1'b0, evicted_data: '0, last: 1'b1};
        state_next = bcl_pkg::S_EMIT;
      end

      bcl_pkg::S_UNLINK: begin
        // shared by delete and head eviction
        valid_next[cur] = 1'b0;
        evd_next = mrsp.dt;
        if (count <= bcl_pkg::CNT_W'(1)) begin
          count_next = '0;
        end else begin
          mreq.nx_we    = 1'b1;
          mreq.nx_addr  = mrsp.pv;
          mreq.nx_wdata = mrsp.nx;
          mreq.pv_we    = 1'b1;
          mreq.pv_addr  = mrsp.nx;
          mreq.pv_wdata = mrsp.pv;
          if (cur == head) head_next = mrsp.nx;
          if (cur == tail) tail_next = mrsp.pv;
          count_next = count - 1'b1;
        end
        if (op == bcl_pkg::OP_DELETE) begin
          res_next = '{status: bcl_pkg::ST_OK, handle: cur, data: '0, size: count_next,
                       evicted_valid: 1'b1, evicted_data: mrsp.dt, last: 1'b1};
          state_next = bcl_pkg::S_EMIT;
        end else begin
          state_next = bcl_pkg::S_INSERT;
        end
      end

      bcl_pkg::S_INSERT: begin
        cur_next = bcl_pkg::first_free(valid);
        valid_next[cur_next] = 1'b1;
        mreq.dt_we    = 1'b1;
        mreq.dt_addr  = cur_next;
        mreq.dt_wdata = din;
        if (count == '0) begin
          mreq.nx_we    = 1'b1;
          mreq.nx_addr  = cur_next;
          mreq.nx_wdata = cur_next;
          mreq.pv_we    = 1'b1;
          mreq.pv_addr  = cur_next;
          mreq.pv_wdata = cur_next;
          head_next  = cur_next;
          tail_next  = cur_next;
          count_next = bcl_pkg::CNT_W'(1);
          res_next = '{status: bcl_pkg::ST_OK, handle: cur_next, data: '0,
                       size: bcl_pkg::CNT_W'(1), evicted_valid: ev, evicted_data: evd,
                       last: 1'b1};
          state_next = bcl_pkg::S_EMIT;
        end else begin
          ins_before_next = (op == bcl_pkg::OP_ADD_FIRST) || rwh ||
                            (op == bcl_pkg::OP_ADD_BEFORE);
          if (op == bcl_pkg::OP_ADD_FIRST || rwh) rr_next = head;
          else if (op == bcl_pkg::OP_ADD_LAST) rr_next = tail;
          else rr_next = ref_h;
          mreq.rd_addr = rr_next;
          state_next = bcl_pkg::S_INS_RD;
        end
      end

      bcl_pkg::S_INS_RD: begin
        // links of the new slot first
        nb_next = ins_before ? mrsp.pv : mrsp.nx;
        mreq.nx_we    = 1'b1;
        mreq.nx_addr  = cur;
        mreq.nx_wdata = ins_before ? rr : mrsp.nx;
        mreq.pv_we    = 1'b1;
        mreq.pv_addr  = cur;
        mreq.pv_wdata = ins_before ? mrsp.pv : rr;
        state_next = bcl_pkg::S_INS_FIX;
      end

      bcl_pkg::S_INS_FIX: begin
        mreq.nx_we    = 1'b1;
        mreq.nx_addr  = ins_before ? nb : rr;
        mreq.nx_wdata = cur;
        mreq.pv_we    = 1'b1;
        mreq.pv_addr  = ins_before ? rr : nb;
        mreq.pv_wdata = cur;
        if (ins_before && rr == head) head_next = cur;
        if (!ins_before && rr == tail) tail_next = cur;
        count_next = count + 1'b1;
        res_next = '{status: bcl_pkg::ST_OK, handle: cur, data: '0, size: count_next,
                     evicted_valid: ev, evicted_data: evd, last: 1'b1};
        state_next = bcl_pkg::S_EMIT;
      end

      bcl_pkg::S_WALK_RD: begin
        res_next = '{status: bcl_pkg::ST_OK, handle: cur, data: mrsp.dt,
                     size: (op == bcl_pkg::OP_WALK) ? count : '0,
                     evicted_valid: 1'b0, evicted_data: '0,
                     last: (walk_i == count - 1'b1)};
        if (op == bcl_pkg::OP_CLEAR) begin
          valid_next[cur] = 1'b0;
          if (walk_i == count - 1'b1) count_next = '0;
        end
        cur_next    = mrsp.nx;
        walk_i_next = walk_i + 1'b1;
        state_next  = bcl_pkg::S_EMIT;
      end

      bcl_pkg::S_EMIT: begin
        if (take) begin
          if (res.last) begin
            state_next = bcl_pkg::S_IDLE;
          end else begin
            mreq.rd_addr = cur;
            state_next = bcl_pkg::S_WALK_RD;
          end
        end
      end

      default: state_next = bcl_pkg::S_IDLE;
    endcase
  end

endmodule

>>> sv/bounded_circular_list_engine.sv
`timescale 1ns / 1ps
// bounded circular doubly linked list over a pool of node slots
// s_* carries one command per transfer; m_* returns its results, the final
// one of a command marked by m_tlast. cfg_* writes max_entries (index 0)
// and drop_policy (index 1); the user must write them only while the engine
// is idle; the block itself does not enforce this.
// one command at a time: s_tready is high only while the engine is idle.
// path from accept to first result: errors and size query DECODE only,
//   first/last/data then QUERY_RD, next/prev LINK_RD and QUERY_RD, delete
//   UNLINK, add INSERT, INS_RD, INS_FIX (INSERT only if empty, UNLINK first
//   on eviction), walk/clear WALK_RD, repeated after each emitted result.
// s_tready rises again in the cycle after the last result is loaded.
// the node memory has one read port; an insertion needs two write passes.
// m_tvalid holds with its payload until m_tready; the sequencer waits on
// a full output register, so no result is lost or repeated.
// synchronous reset empties the list and clears state, config and m_tvalid;
// no pass over the node memory is needed since only valid slots are ever read.
module bounded_circular_list_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bcl_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // operation, node_handle, data
  input  logic [bcl_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status, handle_out, data_out, size_out, evicted_valid, evicted_data, pad
  output logic [bcl_pkg::OUT_W-1:0]   m_tdata,
  output logic                        m_tlast
);

  bcl_pkg::mem_req_t mreq;
  bcl_pkg::mem_rsp_t mrsp;
  bcl_pkg::result_t  res;
  logic              emit, take;

  bcl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_data(s_tdata), .emit(emit), .res(res), .take(take),
    .mreq(mreq), .mrsp(mrsp)
  );

  bcl_node_ram u_ram (.clk(clk), .req(mreq), .rsp(mrsp));

  bcl_out_reg u_out (
    .clk(clk), .rst(rst), .emit(emit), .res(res), .take(take),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule

>>> sv/bcl_checker.sv
`timescale 1ns / 1ps
`include "bounded_circular_list_engine_macros.svh"
module bcl_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [bcl_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);

  `BCL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `BCL_ASSERT_NEXT(a_busy_after_cmd, s_tvalid && s_tready, !s_tready)
  `BCL_ASSERT_NOW(a_size_range, m_tvalid, m_tdata[42:38] <= 5'd16)
  `BCL_ASSERT_NOW(a_error_single, m_tvalid && m_tdata[1:0] != 2'd0, m_tlast)
  `BCL_ASSERT_NOW(a_evict_ok, m_tvalid && m_tdata[43], m_tdata[1:0] == 2'd0 && m_tlast)

endmodule

bind bounded_circular_list_engine bcl_checker u_checker (.*);
